// ===== design/brf_pkg.sv =====
// Package for the byte ring FIFO with commit pointer: sizes, item kinds,
// count helper. No dependencies.
`default_nettype none
package brf_pkg;
	localparam int unsigned SIZE = 1024;           // power of two, 256..1024
	localparam int unsigned PW   = $clog2(SIZE);   // pointer width
	localparam int unsigned LW   = 10;             // length / count width
	localparam int unsigned BW   = 8;              // data width

	typedef logic [PW-1:0] ptr_t;
	typedef logic [LW-1:0] len_t;
	typedef logic [BW-1:0] byte_t;

	typedef enum logic [1:0] {
		KIND_WRITE = 2'd0,
		KIND_READ  = 2'd1,
		KIND_GROUP_BEGIN = 2'd2,
		KIND_GROUP_END   = 2'd3
	} kind_t;

	// Pointer distance taken to the low count bits.
	function automatic len_t to_count(input ptr_t x);
		logic [31:0] w;
		w = 32'(x);
		return w[LW-1:0];
	endfunction
endpackage
`default_nettype wire

// ===== design/brf_if.sv =====
// Stream interfaces (valid/ready plus payload) for the byte ring FIFO.
// Depends on brf_pkg.
`default_nettype none
interface brf_item_if import brf_pkg::*; ();
	logic  valid;
	logic  ready;
	kind_t kind;
	logic  block_start;
	len_t  block_length;
	byte_t write_byte;
	modport source (output valid, kind, block_start, block_length, write_byte, input ready);
	modport sink   (input valid, kind, block_start, block_length, write_byte, output ready);
endinterface

interface brf_result_if import brf_pkg::*; ();
	logic  valid;
	logic  ready;
	byte_t read_byte;
	logic  status;
	logic  block_done;
	len_t  readable_count;
	len_t  writable_count;
	modport source (output valid, read_byte, status, block_done, readable_count,
		writable_count, input ready);
	modport sink   (input valid, read_byte, status, block_done, readable_count,
		writable_count, output ready);
endinterface
`default_nettype wire

// ===== design/byte_ring_fifo_with_commit.sv =====
// Top level of the byte ring FIFO with all-or-nothing block transfers and a
// commit pointer. Depends on brf_pkg and the interfaces in brf_if.sv.
//
//  channel   dir  payload                                            transfer when
//  items     in   kind, block_start, block_length, write_byte        valid && ready
//  results   out  read_byte, status, block_done, readable_count,     valid && ready
//                 writable_count
//
// One item per clock cycle sustained while results are taken. A result passes
// the byte store read port and stage 1, then the output register.
// Pointer and block state live in flops and update in the accept cycle, so
// consecutive items see each other without forwarding.
// Reset clears all control state at once; the byte store is not cleared,
// since only committed (written) bytes are ever read out.
// A stalled output holds in the output register while the stage behind it
// still takes one more item; items.ready drops only when both are full.
`default_nettype none
module byte_ring_fifo_with_commit import brf_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	brf_item_if.sink      items,
	brf_result_if.source  results
);
	typedef struct packed {
		logic  rd_hit;      // read_byte comes from the store
		logic  status;
		logic  block_done;
		len_t  readable_count;
		len_t  writable_count;
	} stage_t;

	typedef struct packed {
		byte_t read_byte;
		logic  status;
		logic  block_done;
		len_t  readable_count;
		len_t  writable_count;
	} result_t;

	// Byte store: at most one write or one read per accepted item.
	byte_t mem [SIZE];
	byte_t mem_rd_q;

	// Pointers and block tracking
	ptr_t wp_q, rdp_q, rp_q;
	ptr_t woff_q, roff_q;
	len_t wrem_q, rrem_q;
	logic wrej_q, rrej_q, in_group_q;

	stage_t  st_s1;
	logic    valid_s1;
	result_t out_q;
	logic    out_valid_q;

	logic out_adv, accept;
	assign out_adv = !out_valid_q || results.ready;
	assign items.ready = !valid_s1 || out_adv;
	assign accept = items.valid && items.ready;

	// Next-state of one step
	ptr_t wp_n, rdp_n, rp_n, woff_n, roff_n, wfree, rfill, addr;
	len_t wrem_n, rrem_n;
	logic wrej_n, rrej_n, grp_n, mem_we, mem_re, status_n, done_n;

	always_comb begin
		wp_n = wp_q; rdp_n = rdp_q; rp_n = rp_q;
		woff_n = woff_q; roff_n = roff_q;
		wrem_n = wrem_q; rrem_n = rrem_q;
		wrej_n = wrej_q; rrej_n = rrej_q; grp_n = in_group_q;
		mem_we = 1'b0; mem_re = 1'b0; status_n = 1'b0; done_n = 1'b0;
		addr = wp_q + woff_q;
		wfree = rp_q - wp_q - ptr_t'(1);
		rfill = rdp_q - rp_q;
		case (items.kind)
			KIND_WRITE: begin
				if (items.block_start) begin
					woff_n = '0;
					wrem_n = items.block_length;
					wrej_n = 17'(items.block_length) > 17'(wfree);
				end
				addr = wp_q + woff_n;
				if (wrem_n != '0) begin
					wrem_n = wrem_n - len_t'(1);
					if (wrej_n) begin
						status_n = 1'b1;
					end else begin
						mem_we = 1'b1;
						woff_n = woff_n + ptr_t'(1);
					end
					if (wrem_n == '0) begin
						done_n = 1'b1;
						if (!wrej_n) begin
							wp_n = wp_q + woff_n;
							if (!in_group_q) rdp_n = wp_n;
						end
						wrej_n = 1'b0;
						woff_n = '0;
					end
				end
			end
			KIND_READ: begin
				if (items.block_start) begin
					roff_n = '0;
					rrem_n = items.block_length;
					rrej_n = 17'(items.block_length) > 17'(rfill);
				end
				addr = rp_q + roff_n;
				if (rrem_n != '0) begin
					rrem_n = rrem_n - len_t'(1);
					if (rrej_n) begin
						status_n = 1'b1;
					end else begin
						mem_re = 1'b1;
						roff_n = roff_n + ptr_t'(1);
					end
					if (rrem_n == '0) begin
						done_n = 1'b1;
						if (!rrej_n) rp_n = rp_q + roff_n;
						rrej_n = 1'b0;
						roff_n = '0;
					end
				end
			end
			KIND_GROUP_BEGIN: grp_n = 1'b1;
			KIND_GROUP_END: begin
				grp_n = 1'b0;
				rdp_n = wp_q;
			end
			default: ;
		endcase
	end

	// Store port: write data or read data registered.
	always_ff @(posedge clk) begin
		if (accept && mem_we) mem[addr] <= items.write_byte;
		if (accept && mem_re) mem_rd_q <= mem[addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rdp_q <= '0; rp_q <= '0;
			woff_q <= '0; roff_q <= '0; wrem_q <= '0; rrem_q <= '0;
			wrej_q <= 1'b0; rrej_q <= 1'b0; in_group_q <= 1'b0;
		end else if (accept) begin
			wp_q <= wp_n; rdp_q <= rdp_n; rp_q <= rp_n;
			woff_q <= woff_n; roff_q <= roff_n; wrem_q <= wrem_n; rrem_q <= rrem_n;
			wrej_q <= wrej_n; rrej_q <= rrej_n; in_group_q <= grp_n;
		end
	end

	// Stage 1: waits for the store read; counts come from post-step pointers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (out_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			st_s1.rd_hit         <= mem_re;
			st_s1.status         <= status_n;
			st_s1.block_done     <= done_n;
			st_s1.readable_count <= to_count(rdp_n - rp_n);
			st_s1.writable_count <= to_count(rp_n - wp_n - ptr_t'(1));
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_adv && valid_s1) begin
			out_q.read_byte      <= st_s1.rd_hit ? mem_rd_q : '0;
			out_q.status         <= st_s1.status;
			out_q.block_done     <= st_s1.block_done;
			out_q.readable_count <= st_s1.readable_count;
			out_q.writable_count <= st_s1.writable_count;
		end
	end

	assign results.valid          = out_valid_q;
	assign results.read_byte      = out_q.read_byte;
	assign results.status         = out_q.status;
	assign results.block_done     = out_q.block_done;
	assign results.readable_count = out_q.readable_count;
	assign results.writable_count = out_q.writable_count;

	// Committed region never runs past the write pointer.
	a_commit_behind_write: assert property (@(posedge clk) disable iff (!arst_n)
		ptr_t'(rdp_q - rp_q) <= ptr_t'(wp_q - rp_q))
		else $error("readable pointer ahead of write pointer");

	// A rejecting block always has items left to consume.
	a_reject_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(wrej_q -> wrem_q != '0) && (rrej_q -> rrem_q != '0))
		else $error("reject flag set with no block in progress");

	// A held stage-1 result is not lost while the output stalls.
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !out_adv |=> valid_s1 && $stable(st_s1))
		else $error("stage 1 result dropped under stall");

	// An empty stage 1 always takes an item.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> items.ready)
		else $error("items not ready with stage 1 empty");
endmodule
`default_nettype wire
